// File: sv/psq_pkg.sv
// Package for the priority slot queue: field widths, status and mode codes,
// and the packed layout of one slot word held in the slot RAM.
// Depends on nothing; used by the top level priority_slot_queue_oldest_first.
`default_nettype none

package psq_pkg;

  // Field widths of the transactions.
  localparam int ID_W     = 12;
  localparam int PRIO_W   = 4;
  localparam int STAMP_W  = 32;
  localparam int STATUS_W = 2;
  localparam int INDEX_W  = 6;

  // Default table size and reset value of the priority cutoff.
  localparam int                SLOT_COUNT_DEF = 64;
  localparam logic [PRIO_W-1:0] CUTOFF_RESET   = 4'd6;

  // Operation requested by an input transaction.
  localparam logic MODE_INSERT  = 1'b0;
  localparam logic MODE_EXTRACT = 1'b1;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    STATUS_INSERTED  = 2'd0,
    STATUS_FULL      = 2'd1,
    STATUS_EXTRACTED = 2'd2,
    STATUS_NONE      = 2'd3
  } status_t;

  // One slot as stored in the RAM; an all-zero word is a free slot.
  typedef struct packed {
    logic               valid;
    logic [ID_W-1:0]    id;
    logic [PRIO_W-1:0]  prio;
    logic [STAMP_W-1:0] arrival;
  } slot_word_t;

  localparam int SLOT_W = $bits(slot_word_t);

endpackage

`default_nettype wire

// File: sv/psq_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Standalone; used for the slot table of the priority slot queue.
`default_nettype none

module psq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: sv/priority_slot_queue_oldest_first.sv
// Top level of the priority slot queue: sequencer, one slot comparator and
// the output register. Depends on psq_pkg and the slot RAM psq_ram.
// An insert into slot k gives its result once slot k is judged free; a full
// insert and every extract give theirs after all SLOT_COUNT slots are judged.
// Throughput: one transaction at a time, the next taken only after the last
// result is loaded; the scan reads one RAM slot per cycle.
// Reset: a clearing pass frees every slot, inputs stall.
`default_nettype none

module priority_slot_queue_oldest_first #(
  parameter int SLOT_COUNT = psq_pkg::SLOT_COUNT_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // Configuration: priority cutoff.
  input  wire logic                          cfg_write,
  input  wire logic [psq_pkg::PRIO_W-1:0]    cfg_data,
  // Input channel.
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic                          mode,
  input  wire logic [psq_pkg::ID_W-1:0]      entry_id,
  input  wire logic [psq_pkg::PRIO_W-1:0]    entry_priority,
  input  wire logic [psq_pkg::STAMP_W-1:0]   arrival_stamp,
  // Output channel.
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [psq_pkg::STATUS_W-1:0]       status,
  output logic [psq_pkg::INDEX_W-1:0]        slot_index,
  output logic [psq_pkg::ID_W-1:0]           out_id,
  output logic [psq_pkg::PRIO_W-1:0]         out_priority,
  output logic [psq_pkg::STAMP_W-1:0]        out_arrival
);

  import psq_pkg::*;

  localparam int AW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CW = $clog2(SLOT_COUNT + 1);

  typedef enum logic [3:0] {
    ST_CLEAR  = 4'b0001,
    ST_IDLE   = 4'b0010,
    ST_SCAN   = 4'b0100,
    ST_FINISH = 4'b1000
  } state_t;

  state_t             state;
  logic [PRIO_W-1:0]  priority_cutoff;
  logic [CW-1:0]      issue_cnt;
  logic               chk_vld;
  logic [AW-1:0]      chk_slot;
  logic               found;
  logic [AW-1:0]      best_slot;
  logic [ID_W-1:0]    best_id;
  logic [PRIO_W-1:0]  best_prio;
  logic [STAMP_W-1:0] best_arr;

  // Latched input transaction.
  logic               op_mode;
  logic [ID_W-1:0]    op_id;
  logic [PRIO_W-1:0]  op_prio;
  logic [STAMP_W-1:0] op_arr;

  // Slot RAM signals.
  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  slot_word_t         ram_wdata;
  logic [SLOT_W-1:0]  ram_rdata;
  slot_word_t         rd;

  logic               issue_more;
  logic               last_slot;
  logic               eligible;
  logic               better;
  logic               out_load;
  status_t            res_status;
  logic [AW+INDEX_W-1:0] slot_wide;

  psq_ram #(
    .WIDTH(SLOT_W),
    .DEPTH(SLOT_COUNT)
  ) u_slot_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(issue_cnt[AW-1:0]),
    .rdata(ram_rdata)
  );

  // Shared slot comparator: judges the slot read in the previous cycle.
  always_comb begin
    rd         = slot_word_t'(ram_rdata);
    issue_more = (issue_cnt < CW'(SLOT_COUNT));
    last_slot  = (chk_slot == AW'(SLOT_COUNT - 1));
    eligible   = rd.valid && (rd.prio <= priority_cutoff);
    better     = !found || (rd.prio < best_prio) ||
                 ((rd.prio == best_prio) && (rd.arrival < best_arr));
  end

  // RAM writes: zeros during the clearing pass, the chosen slot at the end.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = best_slot;
    ram_wdata = '0;
    case (state)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = issue_cnt[AW-1:0];
      end
      ST_FINISH: begin
        ram_we = found;
        if (op_mode == MODE_INSERT) begin
          ram_wdata = '{valid: 1'b1, id: op_id, prio: op_prio, arrival: op_arr};
        end
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  // Result status and output loading.
  always_comb begin
    if (op_mode == MODE_INSERT) begin
      res_status = found ? STATUS_INSERTED : STATUS_FULL;
    end else begin
      res_status = found ? STATUS_EXTRACTED : STATUS_NONE;
    end
    out_load  = (state == ST_FINISH) && (!out_valid || !out_stall);
    slot_wide = {{INDEX_W{1'b0}}, best_slot};
  end

  assign in_stall = (state != ST_IDLE);

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      priority_cutoff <= CUTOFF_RESET;
    end else if (cfg_write) begin
      priority_cutoff <= cfg_data;
    end
  end

  // Sequencer: clearing pass, scan of the slots (an insert stops at the first free one), then write-back and result.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      issue_cnt <= '0;
      chk_vld   <= 1'b0;
      found     <= 1'b0;
    end else begin
      case (state)
        ST_CLEAR: begin
          if (issue_cnt == CW'(SLOT_COUNT - 1)) begin
            state <= ST_IDLE;
          end
          issue_cnt <= issue_cnt + CW'(1);
        end
        ST_IDLE: begin
          if (in_valid) begin
            issue_cnt <= '0;
            chk_vld   <= 1'b0;
            found     <= 1'b0;
            state     <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (issue_more) begin
            issue_cnt <= issue_cnt + CW'(1);
          end
          chk_vld <= issue_more;
          if (chk_vld) begin
            if (op_mode == MODE_INSERT) begin
              if (!rd.valid) begin
                found <= 1'b1;
                state <= ST_FINISH;
              end else if (last_slot) begin
                state <= ST_FINISH;
              end
            end else begin
              if (eligible && better) begin
                found <= 1'b1;
              end
              if (last_slot) begin
                state <= ST_FINISH;
              end
            end
          end
        end
        ST_FINISH: begin
          if (out_load) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_CLEAR;
        end
      endcase
    end
  end

  // Transaction latch and best-candidate registers.
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid) begin
      op_mode <= mode;
      op_id   <= entry_id;
      op_prio <= entry_priority;
      op_arr  <= arrival_stamp;
    end
    if (state == ST_SCAN && chk_vld) begin
      if (op_mode == MODE_INSERT) begin
        if (!rd.valid && !found) begin
          best_slot <= chk_slot;
        end
      end else if (eligible && better) begin
        best_slot <= chk_slot;
        best_id   <= rd.id;
        best_prio <= rd.prio;
        best_arr  <= rd.arrival;
      end
    end
    chk_slot <= issue_cnt[AW-1:0];
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      status       <= res_status;
      slot_index   <= found ? slot_wide[INDEX_W-1:0] : '0;
      out_id       <= '0;
      out_priority <= '0;
      out_arrival  <= '0;
      if (op_mode == MODE_EXTRACT && found) begin
        out_id       <= best_id;
        out_priority <= best_prio;
        out_arrival  <= best_arr;
      end
    end
  end

  // A new result only ever comes out of the finishing step.
  a_result_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_FINISH))
    else $error("result raised outside the finishing step");

  // The slot RAM is written only when clearing or finishing a transaction.
  a_ram_write_phase: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == ST_CLEAR || state == ST_FINISH))
    else $error("slot RAM written outside clear or finish");

  // Failed operations carry no slot and no entry.
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status == STATUS_FULL || status == STATUS_NONE)) |->
      (slot_index == '0 && out_id == '0 && out_priority == '0 && out_arrival == '0))
    else $error("failed operation reports a slot or entry");

  // An extracted entry respects the priority cutoff.
  a_extract_cutoff: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == STATUS_EXTRACTED) |-> (out_priority <= priority_cutoff))
    else $error("extracted entry is above the priority cutoff");

  // A transaction is only taken in the idle state.
  a_accept_idle: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (state == ST_SCAN))
    else $error("accepted transaction did not start a scan");

endmodule

`default_nettype wire
